// ===== hw/rtl/keyframe_vec3_interpolator_assert.svh =====
// Assertion macros shared by the interpolator modules.
`ifndef KEYFRAME_VEC3_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_VEC3_INTERPOLATOR_ASSERT_SVH

// An antecedent that must be followed by a consequent in the same cycle.
`define KVI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// An antecedent that must be followed by a consequent in the next cycle.
`define KVI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/kvi_pkg.sv =====
`timescale 1ns / 1ps
package kvi_pkg;

  localparam int unsigned MaxKeysDefault = 64;

  typedef enum logic [1:0] {
    CmdClear  = 2'd0,
    CmdAppend = 2'd1,
    CmdQuery  = 2'd2,
    CmdNone   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StInterp  = 2'd0,
    StHeld    = 2'd1,
    StFewKeys = 2'd2,
    StZeroSpn = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic append;
    logic load_query;
    logic rd_search;
    logic rd_pair;
    logic lat_pair;
    logic div_start;
    logic div_step;
    logic mul_start;
    logic mul_step;
    logic step_idx;
    logic idx_from_last;
    logic emit_zero;
    logic emit_held;
    logic emit_lo;
    logic emit_blend;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic few_keys;
    logic search_hit;
    logic search_end;
    logic span_bad;
    logic div_done;
    logic mul_done;
  } stat_t;

endpackage

// ===== hw/rtl/kvi_datapath.sv =====
`timescale 1ns / 1ps
`include "keyframe_vec3_interpolator_assert.svh"
module kvi_datapath #(
  parameter int unsigned MaxKeys = kvi_pkg::MaxKeysDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kvi_pkg::cmd_t      cmd_i,
  output kvi_pkg::stat_t     stat_o,
  input  logic [31:0]        key_time_i,
  input  logic [31:0]        key_x_i,
  input  logic [31:0]        key_y_i,
  input  logic [31:0]        key_z_i,
  input  logic [31:0]        query_time_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [31:0]        res_x_o,
  output logic [31:0]        res_y_o,
  output logic [31:0]        res_z_o,
  output logic [1:0]         res_status_o
);
  localparam int unsigned IdxW = $clog2(MaxKeys);
  localparam int unsigned CntW = $clog2(MaxKeys + 1);

  logic [31:0] time_mem [MaxKeys];
  logic [95:0] vec_mem  [MaxKeys];

  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic [31:0] q_q, trd_q, t0_q, t1_q;
  logic [95:0] vrd_q, va_q, vb_q;
  logic [IdxW-1:0] rd_addr;

  // Divider state: restoring, one quotient bit per cycle, 49 bits wide.
  logic [48:0] num_q, quo_q;
  logic [32:0] rem_q;
  logic [31:0] den_q;
  logic [5:0]  dcnt_q;
  // Multiplier state: shift-add over the 17 factor bits, three lanes.
  logic [16:0] f_q;
  logic [4:0]  mcnt_q;
  logic signed [33:0] dlt_q [3];
  logic signed [50:0] acc_q [3];

  logic        ov_q;
  logic [95:0] ores_q;
  logic [1:0]  ost_q;

  assign rd_addr = cmd_i.rd_pair ? (idx_q - IdxW'(1)) : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.append && (count_q < CntW'(MaxKeys))) begin
      time_mem[count_q[IdxW-1:0]] <= key_time_i;
      vec_mem[count_q[IdxW-1:0]]  <= {key_z_i, key_y_i, key_x_i};
    end
    trd_q <= time_mem[rd_addr];
    vrd_q <= vec_mem[rd_addr];
  end

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  assign rem_sh  = {rem_q[31:0], num_q[48]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  logic [31:0] qc;
  assign qc = (q_q < t0_q) ? t0_q : ((q_q > t1_q) ? t1_q : q_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
      ov_q    <= 1'b0;
      dcnt_q  <= '0;
      mcnt_q  <= '0;
    end else begin
      if (cmd_i.clear) count_q <= '0;
      else if (cmd_i.append && (count_q < CntW'(MaxKeys))) count_q <= count_q + CntW'(1);
      if (cmd_i.load_query) begin
        q_q   <= query_time_i;
        idx_q <= IdxW'(1);
      end else if (cmd_i.step_idx) begin
        idx_q <= idx_q + IdxW'(1);
      end else if (cmd_i.idx_from_last) begin
        idx_q <= IdxW'(count_q - CntW'(1));
      end
      if (cmd_i.rd_search) t1_q <= trd_q;
      if (cmd_i.lat_pair) begin
        t0_q <= trd_q;
        va_q <= vrd_q;
      end
      if (cmd_i.rd_search) vb_q <= vrd_q;
      if (cmd_i.div_start) begin
        num_q  <= {1'b0, qc - t0_q, 16'h0};
        den_q  <= t1_q - t0_q;
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= 6'd49;
      end else if (cmd_i.div_step && dcnt_q != 6'd0) begin
        num_q  <= {num_q[47:0], 1'b0};
        if (!rem_sub[32]) begin
          rem_q <= rem_sub;
          quo_q <= {quo_q[47:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[47:0], 1'b0};
        end
        dcnt_q <= dcnt_q - 6'd1;
      end
      if (cmd_i.mul_start) begin
        f_q    <= quo_q[16:0];
        mcnt_q <= 5'd17;
        for (int k = 0; k < 3; k++) begin
          dlt_q[k] <= $signed({vb_q[32*k+31], vb_q[32*k +: 32]})
                    - $signed({va_q[32*k+31], va_q[32*k +: 32]});
          acc_q[k] <= '0;
        end
      end else if (cmd_i.mul_step && mcnt_q != 5'd0) begin
        for (int k = 0; k < 3; k++) begin
          acc_q[k] <= (acc_q[k] <<< 1)
                    + (f_q[16] ? 51'(dlt_q[k]) : 51'sd0);
        end
        f_q    <= {f_q[15:0], 1'b0};
        mcnt_q <= mcnt_q - 5'd1;
      end
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (cmd_i.emit_zero || cmd_i.emit_held || cmd_i.emit_lo || cmd_i.emit_blend)
        ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_zero) begin
      ores_q <= '0;
      ost_q  <= kvi_pkg::StFewKeys;
    end else if (cmd_i.emit_held) begin
      ores_q <= vrd_q;
      ost_q  <= kvi_pkg::StHeld;
    end else if (cmd_i.emit_lo) begin
      ores_q <= va_q;
      ost_q  <= kvi_pkg::StZeroSpn;
    end else if (cmd_i.emit_blend) begin
      for (int k = 0; k < 3; k++) begin
        ores_q[32*k +: 32] <= va_q[32*k +: 32] + 32'(acc_q[k] >>> 16);
      end
      ost_q <= kvi_pkg::StInterp;
    end
  end

  assign stat_o.few_keys   = count_q < CntW'(2);
  assign stat_o.search_hit = !(trd_q < q_q);
  assign stat_o.search_end = (CntW'(idx_q) + CntW'(1)) >= count_q;
  assign stat_o.span_bad   = !(t1_q > t0_q);
  assign stat_o.div_done   = dcnt_q == 6'd0;
  assign stat_o.mul_done   = mcnt_q == 5'd0;

  assign out_valid_o  = ov_q;
  assign res_x_o      = ores_q[31:0];
  assign res_y_o      = ores_q[63:32];
  assign res_z_o      = ores_q[95:64];
  assign res_status_o = ost_q;

  `KVI_ASSERT_NEXT(a_hold, clk_i, rst_ni, ov_q && !out_ready_i, ov_q, "result dropped")
  `KVI_ASSERT_IMPL(a_cnt, clk_i, rst_ni, 1'b1, count_q <= CntW'(MaxKeys), "count overflow")
  `KVI_ASSERT_NEXT(a_div, clk_i, rst_ni, cmd_i.div_start, dcnt_q == 6'd49, "divider not loaded")
endmodule

// ===== hw/rtl/kvi_ctrl.sv =====
`timescale 1ns / 1ps
`include "keyframe_vec3_interpolator_assert.svh"
module kvi_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     command_i,
  input  logic           out_busy_i,
  input  kvi_pkg::stat_t stat_i,
  output kvi_pkg::cmd_t  cmd_o
);
  typedef enum logic [3:0] {
    SIdle, SRead, SCheck, SLast, SLastOut, SPair, SPairLat, SDiv, SMul, SEmit
  } state_e;

  state_e state_q;
  logic   acc;

  assign in_ready_o = (state_q == SIdle) && !out_busy_i;
  assign acc        = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o = '0;
    cmd_o.clear  = acc && (command_i == kvi_pkg::CmdClear);
    cmd_o.append = acc && (command_i == kvi_pkg::CmdAppend);
    cmd_o.load_query = acc && (command_i == kvi_pkg::CmdQuery);
    case (state_q)
      SCheck: begin
        cmd_o.rd_search = 1'b1;
        if (!stat_i.search_hit && stat_i.search_end) cmd_o.idx_from_last = 1'b1;
        else if (!stat_i.search_hit) cmd_o.step_idx = 1'b1;
      end
      SLastOut: cmd_o.emit_held = 1'b1;
      SPair:    cmd_o.rd_pair = 1'b1;
      SPairLat: begin
        cmd_o.lat_pair = 1'b1;
      end
      SDiv: begin
        if (stat_i.span_bad) cmd_o.emit_lo = 1'b1;
        else cmd_o.div_start = 1'b1;
      end
      SMul: begin
        if (!stat_i.div_done) cmd_o.div_step = 1'b1;
        else if (stat_i.mul_done) cmd_o.mul_start = 1'b1;
      end
      SEmit: begin
        if (stat_i.mul_done) cmd_o.emit_blend = 1'b1;
        else cmd_o.mul_step = 1'b1;
      end
      default: ;
    endcase
    if (acc && command_i == kvi_pkg::CmdQuery && stat_i.few_keys) begin
      cmd_o.emit_zero  = 1'b1;
      cmd_o.load_query = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      case (state_q)
        SIdle:  if (cmd_o.load_query) state_q <= SRead;
        SRead:  state_q <= SCheck;
        SCheck: begin
          if (stat_i.search_hit) state_q <= SPair;
          else if (stat_i.search_end) state_q <= SLast;
          else state_q <= SRead;
        end
        SLast:    state_q <= SLastOut;
        SLastOut: state_q <= SIdle;
        SPair:    state_q <= SPairLat;
        SPairLat: state_q <= SDiv;
        SDiv:     state_q <= stat_i.span_bad ? SIdle : SMul;
        SMul: begin
          if (stat_i.div_done && stat_i.mul_done) state_q <= SEmit;
        end
        SEmit: begin
          if (stat_i.mul_done) state_q <= SIdle;
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  `KVI_ASSERT_IMPL(a_rdy, clk_i, rst_ni, in_ready_o, state_q == SIdle, "ready while busy")
  `KVI_ASSERT_NEXT(a_q, clk_i, rst_ni, cmd_o.load_query, state_q == SRead, "query lost")
endmodule

// ===== hw/rtl/keyframe_vec3_interpolator.sv =====
`timescale 1ns / 1ps
// Keyframe vector interpolator.
// The slave stream carries commands: tdata holds, from bit 0 up, command (2),
// key_time (32), key_x (32), key_y (32), key_z (32), query_time (32), padded.
// Clear and append give no result. A query gives one result
// on the master stream: tdata from bit 0 holds result_x, result_y, result_z and
// status (2), padded to whole bytes.
// A query walks the key table from index one, reading and then checking each
// entry in turn. The factor then comes from a restoring divider and the blend
// from a shift-add multiplier over the 17 factor bits; a query with fewer than
// two keys stored is answered with a zero result. One item is processed at a
// time.
// Reset empties the table; stored keys are undefined until written.
// A result waits in the output register until its transfer completes; while it
// waits no new command is taken.
module keyframe_vec3_interpolator #(
  parameter int unsigned MaxKeys = kvi_pkg::MaxKeysDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [167:0] s_axis_tdata,  // command, key_time, key_x, key_y, key_z, query_time
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // result_x, result_y, result_z, status
);
  kvi_pkg::cmd_t  cmd;
  kvi_pkg::stat_t stat;
  logic [31:0] rx, ry, rz;
  logic [1:0]  rs;

  kvi_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .command_i  (s_axis_tdata[1:0]),
    .out_busy_i (m_axis_tvalid),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  kvi_datapath #(.MaxKeys(MaxKeys)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .stat_o       (stat),
    .key_time_i   (s_axis_tdata[33:2]),
    .key_x_i      (s_axis_tdata[65:34]),
    .key_y_i      (s_axis_tdata[97:66]),
    .key_z_i      (s_axis_tdata[129:98]),
    .query_time_i (s_axis_tdata[161:130]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .res_x_o      (rx),
    .res_y_o      (ry),
    .res_z_o      (rz),
    .res_status_o (rs)
  );

  assign m_axis_tdata = {6'b0, rs, rz, ry, rx};
endmodule
